FILE: rtl/ohr_pkg.sv
package ohr_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CFG_WIDTH      = 5;

    localparam logic [CFG_WIDTH-1:0] DEPTH_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_DUMP   = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } t_state;

    // control handed from the sequencer to the cell row and output stage
    typedef struct packed {
        logic shift;      // every cell takes its left neighbor
        logic sel_input;  // head cell takes the new word, else the tail wraps around
        logic emit;       // a result beat leaves next cycle
        logic peek;       // result comes from the head cell
        logic empty;      // peek on an empty ring
        logic last;       // final beat of this command
    } t_ctrl;

endpackage

FILE: rtl/ohr_cell.sv
module ohr_cell #(
    parameter int DATA_WIDTH = ohr_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_shift,
    input  logic [DATA_WIDTH-1:0] i_d,
    output logic [DATA_WIDTH-1:0] o_q
);
    import ohr_pkg::*;

    logic [DATA_WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

FILE: rtl/ohr_ctrl.sv
module ohr_ctrl #(
    parameter int DEPTH = ohr_pkg::DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  ohr_pkg::t_cmd                   i_cmd,
    input  logic                            i_cfg_valid,
    input  logic [ohr_pkg::CFG_WIDTH-1:0]   i_cfg_data,
    output logic                            o_busy,
    output logic                            o_cfg_ready,
    output ohr_pkg::t_ctrl                  o_ctrl
);
    import ohr_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [SW-1:0]        r_step, n_step;
    logic [CFG_WIDTH-1:0] r_depth;
    logic [CW-1:0]        w_depth;
    logic                 w_cfg_we;
    t_ctrl                w_ctrl;

    // register value clamped to 1..DEPTH
    always_comb begin
        if (r_depth == '0) begin
            w_depth = CW'(1);
        end else if (int'(r_depth) > DEPTH) begin
            w_depth = CW'(DEPTH);
        end else begin
            w_depth = CW'(r_depth);
        end
    end

    assign o_busy      = (r_state == ST_DUMP);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_step  = r_step;
        w_ctrl  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_cmd)
                        CMD_APPEND: begin
                            w_ctrl.shift     = 1'b1;
                            w_ctrl.sel_input = 1'b1;
                            if (r_count < w_depth) begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_DUMP: begin
                            if (r_count != '0) begin
                                n_state = ST_DUMP;
                                n_step  = '0;
                            end
                        end
                        CMD_PEEK: begin
                            w_ctrl.emit  = 1'b1;
                            w_ctrl.peek  = 1'b1;
                            w_ctrl.last  = 1'b1;
                            w_ctrl.empty = (r_count == '0);
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                // full rotation of the row; the tail cell walks through every slot
                w_ctrl.shift = 1'b1;
                w_ctrl.emit  = (CW'(r_step) >= (CW'(DEPTH) - r_count));
                w_ctrl.last  = (r_step == SW'(DEPTH - 1));
                if (w_ctrl.last) begin
                    n_state = ST_IDLE;
                    n_step  = '0;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
        if (w_cfg_we) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_depth <= DEPTH_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            if (w_cfg_we) begin
                r_depth <= i_cfg_data;
            end
        end
    end

    assign o_ctrl = w_ctrl;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= w_depth)
        else $error("held count exceeds depth");

    a_count_stable_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |=> ($stable(r_count) || $past(w_ctrl.last)))
        else $error("count changed during dump");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.emit && w_ctrl.last) |=> (r_state == ST_IDLE))
        else $error("still busy after last beat");

    a_step_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_step == '0))
        else $error("step counter not cleared");

endmodule

FILE: rtl/overwriting_history_ring_top.sv
// append, peek and clear never raise busy; a peek result appears in the cycle after start
// a dump holds busy for one full rotation of the cell row on a non-empty ring
// and gives one beat per held word, oldest first
// an empty dump gives no beat and never raises busy; results are strobed and cannot be stalled
// synchronous active-low reset empties the ring and sets depth_in_use to 16; stored words are kept
module overwriting_history_ring_top #(
    parameter int DEPTH      = ohr_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ohr_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_cmd,
    input  logic [DATA_WIDTH-1:0]         i_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ohr_pkg::CFG_WIDTH-1:0] i_cfg_data,
    output logic                          o_strobe,
    output logic [DATA_WIDTH-1:0]         o_out_value,
    output logic                          o_status,
    output logic                          o_last
);
    import ohr_pkg::*;

    t_ctrl                 w_ctrl;
    logic [DATA_WIDTH-1:0] w_q [DEPTH];
    logic [DATA_WIDTH-1:0] w_d [DEPTH];

    logic                  r_strobe;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic                  r_status;
    logic                  r_last;

    ohr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (t_cmd'(i_cmd)),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_cfg_ready (o_cfg_ready),
        .o_ctrl      (w_ctrl)
    );

    // head cell holds the newest word; the tail wraps back to the head on a dump
    assign w_d[0] = w_ctrl.sel_input ? i_value : w_q[DEPTH-1];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g > 0) begin : g_link
            assign w_d[g] = w_q[g-1];
        end
        ohr_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_ctrl.shift),
            .i_d     (w_d[g]),
            .o_q     (w_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_ctrl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.peek) begin
            r_out_value <= w_ctrl.empty ? '0 : w_q[0];
        end else begin
            r_out_value <= w_q[DEPTH-1];
        end
        r_status <= w_ctrl.peek & w_ctrl.empty;
        r_last   <= w_ctrl.last;
    end

    assign o_strobe    = r_strobe;
    assign o_out_value = r_out_value;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule
